@@ hdl/set_mean_stddev_outliers_assert.svh @@
// Assertion macros shared by the checker
`ifndef SET_MEAN_STDDEV_OUTLIERS_ASSERT_SVH
`define SET_MEAN_STDDEV_OUTLIERS_ASSERT_SVH
// Implication checked at every edge outside reset
`define SMSO_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define SMSO_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

@@ hdl/smso_pkg.sv @@
package smso_pkg;
  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned SumW = $clog2(Capacity * 255 + 1);
  localparam int unsigned SqW = $clog2(Capacity * 65025 + 1);
  localparam int unsigned QDepth = 2;

  // Item passed from the front to the back
  typedef struct packed {
    logic [7:0] grade;
    logic       final_item;
  } item_t;
endpackage

@@ hdl/smso_front.sv @@
module smso_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      grade_i,
  input  logic            final_item_i,
  output smso_pkg::item_t item_o,
  output logic            item_valid_o,
  input  logic            item_ready_i
);
  import smso_pkg::*;

  item_t             mem_q [QDepth];
  logic              wp_q, rp_q;
  logic [1:0]        cnt_q;
  logic              push, pop;

  assign in_ready_o   = (cnt_q != 2'(QDepth));
  assign item_valid_o = (cnt_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = item_valid_o && item_ready_i;
  assign item_o = mem_q[rp_q];

  // Write the queue payload
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= '{grade: grade_i, final_item: final_item_i};
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ hdl/smso_back.sv @@
module smso_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  smso_pkg::item_t item_i,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [4:0]      set_count_o,
  output logic [15:0]     mean_q8_o,
  output logic [14:0]     deviation_q8_o,
  output logic [7:0]      smallest_o,
  output logic [7:0]      largest_o,
  output logic [7:0]      outlier_value_o,
  output logic            outlier_present_o,
  output logic            final_result_o
);
  import smso_pkg::*;

  typedef enum logic [6:0] {
    SLoad = 7'b0000001, SSq = 7'b0000010, SPrep = 7'b0000100, SDiv = 7'b0001000,
    SSqrt = 7'b0010000, SScan = 7'b0100000, SOut = 7'b1000000
  } state_e;

  localparam int unsigned NumW = SqW + CntW + 1;      // n*sumsq
  localparam int unsigned DivW = NumW + 16;           // dividend width
  localparam int unsigned DenW = 2 * CntW;

  state_e           state_q;
  logic [7:0]       store_q [Capacity];
  logic [CntW-1:0]  count_q, idx_q;
  logic [SumW-1:0]  sum_q;
  logic [7:0]       min_q, max_q;
  logic [SqW-1:0]   sq_q;
  logic [7:0]       rd_q;
  logic             rd_ok_q;
  logic [DivW-1:0]  quo_q;   // dividend shifts out, quotient shifts in
  logic [DenW:0]    rem_q;
  logic [DenW-1:0]  den_q;
  logic [1:0]       phase_q;  // 0 mean division, 1 variance division
  logic [6:0]       step_q;
  logic [15:0]      mean_q;
  logic [31:0]      rad_q;
  logic [16:0]      root_q;
  logic [31:0]      srem_q;
  logic [8:0]       hi_q;
  logic [15:0]      lo_q;
  logic             lo_ok_q, any_q;
  logic [7:0]       pv_q;     // latest outlier, held until the next one or the end
  logic [7:0]       ov_q;
  logic             op_q, ovalid_q, fin_q;
  logic [4:0]       ocnt_q;
  logic [15:0]      omean_q;
  logic [14:0]      odev_q;
  logic [7:0]       omin_q, omax_q;

  logic [DenW:0]    trial;
  logic [31:0]      st;
  logic             cap_ok;
  logic             is_out;
  logic             rd_en;

  assign item_ready_o = (state_q == SLoad);
  assign cap_ok = (count_q != CntW'(Capacity));
  assign trial = {rem_q[DenW-1:0], quo_q[DivW-1]};
  assign st = {srem_q[29:0], rad_q[31:30]};
  assign is_out = ({1'b0, rd_q} > hi_q) || (lo_ok_q && (rd_q < lo_q[15:8]));
  assign rd_en = (state_q != SScan) || !ovalid_q || out_ready_i;

  // Write the value store; advance the read data only when the scan moves
  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i && cap_ok) store_q[count_q[IdxW-1:0]] <= item_i.grade;
    if (rd_en) rd_q <= store_q[idx_q[IdxW-1:0]];
  end

  // Sequence load, statistics and outlier scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad; count_q <= '0; sum_q <= '0; min_q <= 8'd255; max_q <= '0;
      idx_q <= '0; sq_q <= '0; rd_ok_q <= 1'b0; quo_q <= '0; rem_q <= '0; den_q <= '0;
      phase_q <= '0; step_q <= '0; mean_q <= '0; rad_q <= '0; root_q <= '0; srem_q <= '0;
      hi_q <= '0; lo_q <= '0; lo_ok_q <= 1'b0; any_q <= 1'b0; pv_q <= '0;
      ov_q <= '0; op_q <= 1'b0; ovalid_q <= 1'b0; fin_q <= 1'b0;
      ocnt_q <= '0; omean_q <= '0; odev_q <= '0; omin_q <= '0; omax_q <= '0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        SLoad: if (item_valid_i) begin
          if (cap_ok) begin
            count_q <= count_q + 1'b1;
            sum_q <= sum_q + SumW'(item_i.grade);
            if (item_i.grade < min_q) min_q <= item_i.grade;
            if (item_i.grade > max_q) max_q <= item_i.grade;
          end
          if (item_i.final_item) begin
            state_q <= SSq; idx_q <= '0; sq_q <= '0; rd_ok_q <= 1'b0;
          end
        end
        // Accumulate squares, one stored value a cycle
        SSq: begin
          if (rd_ok_q) sq_q <= sq_q + SqW'(rd_q) * SqW'(rd_q);
          rd_ok_q <= (idx_q < count_q);
          if (idx_q < count_q) idx_q <= idx_q + 1'b1;
          else if (!rd_ok_q) state_q <= SPrep;
        end
        // Load the mean division
        SPrep: begin
          quo_q <= DivW'({sum_q, 8'd0}); rem_q <= '0;
          den_q <= DenW'(count_q); phase_q <= 2'd0; step_q <= '0;
          state_q <= SDiv;
        end
        // Restoring division, one quotient bit a cycle
        SDiv: begin
          if (trial >= {1'b0, den_q}) begin
            rem_q <= trial - {1'b0, den_q};
            quo_q <= {quo_q[DivW-2:0], 1'b1};
          end else begin
            rem_q <= trial;
            quo_q <= {quo_q[DivW-2:0], 1'b0};
          end
          step_q <= step_q + 1'b1;
          if (step_q == 7'(DivW - 1)) begin
            step_q <= '0; rem_q <= '0;
            if (phase_q == 2'd0) begin
              mean_q <= 16'({quo_q[DivW-2:0], trial >= {1'b0, den_q}});
              quo_q <= DivW'({NumW'(count_q) * NumW'(sq_q) - NumW'(sum_q) * NumW'(sum_q),
                              16'd0});
              den_q <= DenW'(count_q) * DenW'(count_q);
              phase_q <= 2'd1;
            end else begin
              rad_q <= 32'({quo_q[DivW-2:0], trial >= {1'b0, den_q}});
              root_q <= '0; srem_q <= '0;
              state_q <= SSqrt;
            end
          end
        end
        // Digit-by-digit square root, one result bit a cycle
        SSqrt: begin
          rad_q <= {rad_q[29:0], 2'b00};
          if (st >= {13'd0, root_q[16:0], 2'b01}) begin
            srem_q <= st - {13'd0, root_q[16:0], 2'b01};
            root_q <= {root_q[15:0], 1'b1};
          end else begin
            srem_q <= st;
            root_q <= {root_q[15:0], 1'b0};
          end
          step_q <= step_q + 1'b1;
          if (step_q == 7'd15) state_q <= SScan;
        end
        // Form the limits, then test stored values in order and emit outliers
        SScan: if (!ovalid_q || out_ready_i) begin
          if (step_q == 7'd16) begin
            hi_q <= 9'((17'(mean_q) + 17'(root_q[15:0])) >> 8);
            lo_q <= mean_q - root_q[15:0];
            lo_ok_q <= (mean_q >= root_q[15:0]);
            ocnt_q <= 5'(count_q); omean_q <= mean_q; odev_q <= root_q[14:0];
            omin_q <= min_q; omax_q <= max_q;
            step_q <= 7'd17; idx_q <= '0; rd_ok_q <= 1'b0; any_q <= 1'b0;
          end else begin
            if (rd_ok_q && is_out) begin
              if (any_q) begin
                ov_q <= pv_q; op_q <= 1'b1; fin_q <= 1'b0; ovalid_q <= 1'b1;
              end
              pv_q <= rd_q; any_q <= 1'b1;
            end
            rd_ok_q <= (idx_q < count_q);
            if (idx_q < count_q) idx_q <= idx_q + 1'b1;
            else state_q <= SOut;
          end
        end
        // Close the run: emit the held outlier or the empty result as the last beat
        SOut: if (!ovalid_q || out_ready_i) begin
          ov_q <= any_q ? pv_q : 8'd0; op_q <= any_q; fin_q <= 1'b1; ovalid_q <= 1'b1;
          count_q <= '0; sum_q <= '0; min_q <= 8'd255; max_q <= '0;
          state_q <= SLoad; step_q <= '0;
        end
        default: state_q <= SLoad;
      endcase
    end
  end

  assign out_valid_o      = ovalid_q;
  assign set_count_o      = ocnt_q;
  assign mean_q8_o        = omean_q;
  assign deviation_q8_o   = odev_q;
  assign smallest_o       = omin_q;
  assign largest_o        = omax_q;
  assign outlier_value_o  = ov_q;
  assign outlier_present_o = op_q;
  assign final_result_o   = fin_q;
endmodule

@@ hdl/set_mean_stddev_outliers.sv @@
// Mean, population deviation and outlier finder for up to 16 unsigned 8-bit
// values. Each value is taken through a two-beat queue. The final item starts
// a pass that sums squares, runs two bit-serial divisions and a 16-step square
// root, then scans the store one entry a cycle while the output is not
// stalled, emitting one beat per outlier (or one empty beat), last beat marked;
// each outlier is held back one find so the last can be marked. The statistics
// on the output hold for every beat of a run.
module set_mean_stddev_outliers (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  grade_i,
  input  logic        final_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  set_count_o,
  output logic [15:0] mean_q8_o,
  output logic [14:0] deviation_q8_o,
  output logic [7:0]  smallest_o,
  output logic [7:0]  largest_o,
  output logic [7:0]  outlier_value_o,
  output logic        outlier_present_o,
  output logic        final_result_o
);
  import smso_pkg::*;

  item_t item;
  logic  item_valid, item_ready;

  smso_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .grade_i, .final_item_i,
    .item_o(item), .item_valid_o(item_valid), .item_ready_i(item_ready)
  );

  smso_back u_back (
    .clk_i, .rst_ni, .item_i(item), .item_valid_i(item_valid), .item_ready_o(item_ready),
    .out_valid_o, .out_ready_i, .set_count_o, .mean_q8_o, .deviation_q8_o,
    .smallest_o, .largest_o, .outlier_value_o, .outlier_present_o, .final_result_o
  );
endmodule

@@ hdl/smso_checker.sv @@
`include "set_mean_stddev_outliers_assert.svh"
module smso_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  outlier_value_i,
  input logic        outlier_present_i,
  input logic        final_result_i
);
  // A result beat that waits stays valid
  `SMSO_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  // An empty result holds a zero value
  `SMSO_ASSERT_IMP(a_empty, clk_i, rst_ni, out_valid_i && !outlier_present_i,
    outlier_value_i == 8'd0)
  // An empty result closes the run
  `SMSO_ASSERT_IMP(a_last, clk_i, rst_ni, out_valid_i && !outlier_present_i,
    final_result_i)
endmodule

bind set_mean_stddev_outliers smso_checker u_checker (
  .clk_i, .rst_ni, .out_valid_i(out_valid_o), .out_ready_i,
  .outlier_value_i(outlier_value_o), .outlier_present_i(outlier_present_o),
  .final_result_i(final_result_o)
);

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap = smso_pkg::Capacity;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [4:0]  set_count;
    logic [15:0] mean_q8;
    logic [14:0] deviation_q8;
    logic [7:0]  smallest;
    logic [7:0]  largest;
    logic [7:0]  outlier_value;
    logic        outlier_present;
    logic        final_result;
  } stats_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  grade_i;
  logic        final_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  set_count_o;
  logic [15:0] mean_q8_o;
  logic [14:0] deviation_q8_o;
  logic [7:0]  smallest_o;
  logic [7:0]  largest_o;
  logic [7:0]  outlier_value_o;
  logic        outlier_present_o;
  logic        final_result_o;

  set_mean_stddev_outliers uut (.*);

  smso_pkg::item_t grade_queue[$];
  stats_beat_t     expected_beats[$];
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;
  int unsigned     hold_off = 0;
  int unsigned     burst_left = 0;
  int unsigned     gap_left = 0;

  // Predictor state for the set being loaded
  logic [7:0]  set_values[Cap];
  int unsigned set_fill = 0;
  int unsigned set_sum = 0;
  int unsigned set_min = 255;
  int unsigned set_max = 0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Fold one accepted beat into the set; on the final beat push the results
  task automatic predict_set_stats(smso_pkg::item_t it);
    longint unsigned sumsq = 0, n, num, var_q16;
    longint mean_q8, dev_q8, low_diff, hi_lim;
    stats_beat_t b;
    int found = 0;
    if (set_fill < Cap) begin
      set_values[set_fill] = it.grade;
      set_fill++;
      set_sum += it.grade;
      if (it.grade < set_min) set_min = it.grade;
      if (it.grade > set_max) set_max = it.grade;
    end
    if (!it.final_item) return;
    n = set_fill;
    for (int i = 0; i < set_fill; i++) sumsq += set_values[i] * set_values[i];
    mean_q8 = (longint'(set_sum) << 8) / n;
    num = n * sumsq - longint'(set_sum) * set_sum;
    var_q16 = (num << 16) / (n * n);
    dev_q8 = isqrt(var_q16);
    hi_lim = (mean_q8 + dev_q8) >> 8;
    low_diff = mean_q8 - dev_q8;
    b.set_count = set_fill[4:0];
    b.mean_q8 = mean_q8[15:0];
    b.deviation_q8 = dev_q8[14:0];
    b.smallest = set_min[7:0];
    b.largest = set_max[7:0];
    b.final_result = 0;
    for (int i = 0; i < set_fill; i++) begin
      if (set_values[i] > hi_lim || (low_diff >= 0 && set_values[i] < (low_diff >> 8))) begin
        b.outlier_value = set_values[i];
        b.outlier_present = 1;
        expected_beats.push_back(b);
        found++;
      end
    end
    if (found == 0) begin
      b.outlier_value = 0;
      b.outlier_present = 0;
      expected_beats.push_back(b);
    end
    expected_beats[expected_beats.size() - 1].final_result = 1;
    set_fill = 0;
    set_sum = 0;
    set_min = 255;
    set_max = 0;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic add_set(int unsigned len, int mode);
    smso_pkg::item_t it;
    logic [7:0] base = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: it.grade = 8'($urandom);
        1: it.grade = base;
        2: it.grade = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(base ^ $urandom_range(0, 3));
        default: it.grade = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      endcase
      it.final_item = (i == len - 1);
      grade_queue.push_back(it);
    end
  endtask

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Directed sets, then random sets
  initial begin
    rst_ni = 0;
    add_set(1, 1);
    grade_queue.push_back('{grade: 8'd0, final_item: 1'b0});
    grade_queue.push_back('{grade: 8'd255, final_item: 1'b1});
    add_set(4, 3);
    add_set(Cap + 3, 0);
    // High limit above the 8-bit range: a full set of 255 with one zero at the end
    for (int i = 0; i < Cap; i++) begin
      grade_queue.push_back('{grade: (i == Cap - 1) ? 8'd0 : 8'd255,
                              final_item: (i == Cap - 1)});
    end
    for (int i = 0; i < 26; i++) begin
      case ($urandom_range(0, 9))
        0: add_set($urandom_range(Cap, Cap + 4), 0);
        1: add_set($urandom_range(1, 6), 1);
        2: add_set($urandom_range(2, Cap), 3);
        3, 4, 5: add_set($urandom_range(2, Cap), 2);
        default: add_set($urandom_range(1, Cap), 0);
      endcase
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    while (grade_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("set_mean_stddev_outliers: match");
    end else begin
      $display("set_mean_stddev_outliers: mismatch");
    end
    $finish;
  end

  // Drive beats in bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      grade_i <= 0;
      final_item_i <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_set_stats('{grade: grade_i, final_item: final_item_i});
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 0;
        end else if (grade_queue.size() > 0) begin
          smso_pkg::item_t it;
          it = grade_queue.pop_front();
          in_valid_i <= 1;
          grade_i <= it.grade;
          final_item_i <= it.final_item;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // Stall the result side; one long hold-off early in the run
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 0;
      hold_off = 0;
    end else begin
      if (cycle_count == 200) hold_off = 2000;
      if (hold_off > 0) begin
        hold_off--;
        out_ready_i <= 0;
      end else if ((cycle_count / 500) % 3 == 0) begin
        out_ready_i <= 1;
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Compare each result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("set_mean_stddev_outliers: mismatch");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat, outlier", outlier_value_o, 0);
        end else begin
          stats_beat_t e;
          e = expected_beats.pop_front();
          if (set_count_o !== e.set_count)
            report_mismatch("set_count", set_count_o, e.set_count);
          if (mean_q8_o !== e.mean_q8) report_mismatch("mean_q8", mean_q8_o, e.mean_q8);
          if (deviation_q8_o !== e.deviation_q8)
            report_mismatch("deviation_q8", deviation_q8_o, e.deviation_q8);
          if (smallest_o !== e.smallest) report_mismatch("smallest", smallest_o, e.smallest);
          if (largest_o !== e.largest) report_mismatch("largest", largest_o, e.largest);
          if (outlier_value_o !== e.outlier_value)
            report_mismatch("outlier_value", outlier_value_o, e.outlier_value);
          if (outlier_present_o !== e.outlier_present)
            report_mismatch("outlier_present", outlier_present_o, e.outlier_present);
          if (final_result_o !== e.final_result)
            report_mismatch("final_result", final_result_o, e.final_result);
        end
      end
    end
  end
endmodule
